// ===== sv/frq_pkg.sv =====
// ----------------------------------------------------------------------------
// frq_pkg: shared types and constants for the picture quantizer controller
// Register indexes, field widths, reset values, state codes and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package frq_pkg;

  // Default parameter values
  localparam int FRAC_BITS_DEF = 6;
  localparam int ACC_WIDTH_DEF = 64;

  // Field widths
  localparam int MODE_W     = 1;
  localparam int BYTES_W    = 18;
  localparam int QUANT_W    = 5;
  localparam int BITRATE_W  = 22;
  localparam int BUDGET_W   = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  localparam logic [QUANT_W-1:0] QUANT_MAX = 5'd31;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_QUANT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BITRATE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BUDGET   = 2'd3;

  // Register reset values
  localparam logic                 CTRL_FIXED           = 1'b0;
  localparam logic                 CTRL_RATE            = 1'b1;
  localparam logic [QUANT_W-1:0]   INITIAL_QUANT_RST    = 5'd16;
  localparam logic [BITRATE_W-1:0] TARGET_BITRATE_RST   = 22'd384000;
  localparam logic [BUDGET_W-1:0]  FRAME_BUDGET_RST     = 27'd820115;

  // Item kinds
  localparam logic MODE_BEGIN = 1'b0;
  localparam logic MODE_END   = 1'b1;

  typedef enum logic [3:0] {
    ST_RELOAD,
    ST_IDLE,
    ST_DIV_MEAN,
    ST_DIV_ADJ,
    ST_MUL,
    ST_ROUND,
    ST_EMIT,
    ST_ACC_MUL,
    ST_ACC_ADD
  } ctl_state_t;

  typedef struct packed {
    logic reload;
    logic take_in;
    logic div_start;
    logic div_frac;
    logic cap_mean;
    logic cap_adj;
    logic mul;
    logic round_q;
    logic out_load;
    logic acc_mul;
    logic acc_add;
  } ctl_cmd_t;

  typedef struct packed {
    logic rate_mode;
    logic actual_zero;
    logic div_done;
  } dp_status_t;

endpackage

// ===== sv/frq_div.sv =====
// ----------------------------------------------------------------------------
// frq_div: shared restoring divider, one quotient bit per cycle
// Runs ACC_WIDTH steps, plus FRAC_BITS fraction steps when asked. Keeps the
// low quotient bits and a sticky flag for any bit shifted out on top.
// ----------------------------------------------------------------------------
module frq_div
  import frq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   frac_en,
  input  logic [ACC_WIDTH-1:0]   dividend,
  input  logic [ACC_WIDTH-1:0]   divisor,
  output logic [FRAC_BITS+6:0]   quot,
  output logic                   quot_ovf,
  output logic                   done
);

  localparam int QW = FRAC_BITS + 7;
  localparam int CW = $clog2(ACC_WIDTH + FRAC_BITS + 1);
  localparam logic [CW-1:0] STEPS_INT  = CW'(ACC_WIDTH);
  localparam logic [CW-1:0] STEPS_FRAC = CW'(ACC_WIDTH + FRAC_BITS);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [ACC_WIDTH-1:0] rem_r, rem_nxt;
  logic [ACC_WIDTH-1:0] dvd_r, dvd_nxt;
  logic [ACC_WIDTH-1:0] den_r, den_nxt;
  logic [QW-1:0]        quo_r, quo_nxt;
  logic                 ovf_r, ovf_nxt;

  logic [ACC_WIDTH:0]   trial;
  logic [ACC_WIDTH+1:0] diff;
  logic                 ge;

  assign trial = {rem_r, dvd_r[ACC_WIDTH-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};
  assign ge    = ~diff[ACC_WIDTH+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = frac_en ? STEPS_FRAC : STEPS_INT;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      den_nxt  = divisor;
      quo_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[ACC_WIDTH-1:0] : trial[ACC_WIDTH-1:0];
      dvd_nxt = {dvd_r[ACC_WIDTH-2:0], 1'b0};
      quo_nxt = {quo_r[QW-2:0], ge};
      ovf_nxt = ovf_r | quo_r[QW-1];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign quot     = quo_r;
  assign quot_ovf = ovf_r;
  assign done     = done_r;

endmodule

// ===== sv/frq_datapath.sv =====
// ----------------------------------------------------------------------------
// frq_datapath: accumulators, register file and quantizer arithmetic
// Holds the configuration, the three saturating accumulators and the current
// quantizer, and runs the mean and adjustment divisions on the shared divider.
// ----------------------------------------------------------------------------
module frq_datapath
  import frq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  output dp_status_t            status,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [BYTES_W-1:0]    in_bytes,
  output logic [QUANT_W-1:0]    out_quant
);

  localparam int QW     = FRAC_BITS + 7;
  localparam int AW     = FRAC_BITS + 2;
  localparam int PW     = QW + AW;
  localparam int BITS_W = BYTES_W + 3 + FRAC_BITS;
  localparam int BQP_W  = BYTES_W + QUANT_W;
  localparam int BQ_W   = BQP_W + 3 + FRAC_BITS;
  localparam int SW     = ((ACC_WIDTH > BQ_W) ? ACC_WIDTH : BQ_W) + 1;
  localparam int RLD_W  = BUDGET_W + QUANT_W;

  localparam logic [QW-1:0] ONE_Q  = QW'(1) << FRAC_BITS;
  localparam logic [QW-1:0] MEAN_MAX = QW'(1) << (FRAC_BITS + 6);
  localparam logic [AW-1:0] ONE_A  = AW'(1) << FRAC_BITS;
  localparam logic [AW-1:0] HALF_A = AW'(1) << (FRAC_BITS - 1);
  localparam logic [PW:0]   RND    = (PW+1)'(1) << (2*FRAC_BITS - 1);

  // Configuration registers
  logic                 ctl_mode_r;
  logic [QUANT_W-1:0]   init_q_r;
  logic [BITRATE_W-1:0] bitrate_r;
  logic [BUDGET_W-1:0]  budget_r;

  // Accumulators and working registers
  logic [ACC_WIDTH-1:0] actual_r, wanted_r, bq_r;
  logic [QUANT_W-1:0]   cur_q_r, out_q_r;
  logic [BYTES_W-1:0]   bytes_r;
  logic [BQP_W-1:0]     bqp_r;
  logic [QW-1:0]        mean_r;
  logic [AW-1:0]        adj_r;
  logic [PW-1:0]        prod_r;

  // Divider hookup
  logic                 div_neg;
  logic [ACC_WIDTH-1:0] mag;
  logic [BITRATE_W-1:0] br_eff;
  logic [ACC_WIDTH-1:0] div_dvd, div_dvs;
  logic [QW-1:0]        quot;
  logic                 quot_ovf, div_done;

  // Adjustment and rounding
  logic [FRAC_BITS:0]   err_clip;
  logic [AW-1:0]        adj_dn, adj_nxt;
  logic [PW:0]          prod_rnd;
  logic [QUANT_W-1:0]   round_q;

  // Saturating sums
  logic [SW-1:0]        sum_act, sum_want, sum_bq;
  logic [RLD_W-1:0]     rld_bq;

  assign div_neg = actual_r < wanted_r;
  assign mag     = div_neg ? (wanted_r - actual_r) : (actual_r - wanted_r);
  assign br_eff  = (bitrate_r == '0) ? BITRATE_W'(1) : bitrate_r;
  assign div_dvd = cmd.div_frac ? bq_r : mag;
  assign div_dvs = cmd.div_frac ? actual_r : {{(ACC_WIDTH-BITRATE_W){1'b0}}, br_eff};

  frq_div #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .frac_en  (cmd.div_frac),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quot     (quot),
    .quot_ovf (quot_ovf),
    .done     (div_done)
  );

  always_comb begin
    err_clip = (quot_ovf || quot > ONE_Q) ? ONE_Q[FRAC_BITS:0] : quot[FRAC_BITS:0];
    adj_dn   = ONE_A - {1'b0, err_clip};
    if (div_neg) begin
      adj_nxt = (adj_dn < HALF_A) ? HALF_A : adj_dn;
    end else begin
      adj_nxt = ONE_A + {1'b0, err_clip};
    end
  end

  assign prod_rnd = {1'b0, prod_r} + RND;
  assign round_q  = (|prod_rnd[PW:2*FRAC_BITS+QUANT_W]) ? QUANT_MAX
                                                        : prod_rnd[2*FRAC_BITS+QUANT_W-1:2*FRAC_BITS];

  assign sum_act  = {{(SW-ACC_WIDTH){1'b0}}, actual_r}
                  + {{(SW-BITS_W){1'b0}}, bytes_r, {(3+FRAC_BITS){1'b0}}};
  assign sum_want = {{(SW-ACC_WIDTH){1'b0}}, wanted_r}
                  + {{(SW-BUDGET_W){1'b0}}, budget_r};
  assign sum_bq   = {{(SW-ACC_WIDTH){1'b0}}, bq_r}
                  + {{(SW-BQ_W){1'b0}}, bqp_r, {(3+FRAC_BITS){1'b0}}};
  assign rld_bq   = budget_r * init_q_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_mode_r <= CTRL_RATE;
      init_q_r   <= INITIAL_QUANT_RST;
      bitrate_r  <= TARGET_BITRATE_RST;
      budget_r   <= FRAME_BUDGET_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_CONTROL_MODE:   ctl_mode_r <= cfg_data[0];
        REG_INITIAL_QUANT:  init_q_r   <= cfg_data[QUANT_W-1:0];
        REG_TARGET_BITRATE: bitrate_r  <= cfg_data[BITRATE_W-1:0];
        REG_FRAME_BUDGET:   budget_r   <= cfg_data[BUDGET_W-1:0];
        default:            ctl_mode_r <= ctl_mode_r;
      endcase
    end
  end

  // Accumulators: reloaded by the controller after reset and each write
  always_ff @(posedge clk) begin
    if (cmd.reload) begin
      actual_r <= {{(ACC_WIDTH-BUDGET_W){1'b0}}, budget_r};
      wanted_r <= {{(ACC_WIDTH-BUDGET_W){1'b0}}, budget_r};
      bq_r     <= {{(ACC_WIDTH-RLD_W){1'b0}}, rld_bq};
    end else if (cmd.acc_add) begin
      actual_r <= (|sum_act[SW-1:ACC_WIDTH])  ? '1 : sum_act[ACC_WIDTH-1:0];
      wanted_r <= (|sum_want[SW-1:ACC_WIDTH]) ? '1 : sum_want[ACC_WIDTH-1:0];
      bq_r     <= (|sum_bq[SW-1:ACC_WIDTH])   ? '1 : sum_bq[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reload) begin
      cur_q_r <= init_q_r;
    end else if (cmd.round_q) begin
      cur_q_r <= round_q;
    end
    if (cmd.take_in) begin
      bytes_r <= in_bytes;
    end
    if (cmd.acc_mul) begin
      bqp_r <= bytes_r * cur_q_r;
    end
    if (cmd.cap_mean) begin
      mean_r <= (quot_ovf || quot[QW-1]) ? MEAN_MAX : quot;
    end
    if (cmd.cap_adj) begin
      adj_r <= adj_nxt;
    end
    if (cmd.mul) begin
      prod_r <= mean_r * adj_r;
    end
    if (cmd.out_load) begin
      out_q_r <= cur_q_r;
    end
  end

  assign status.rate_mode   = ctl_mode_r;
  assign status.actual_zero = (actual_r == '0);
  assign status.div_done    = div_done;
  assign out_quant          = out_q_r;

endmodule

// ===== sv/frq_ctrl.sv =====
// ----------------------------------------------------------------------------
// frq_ctrl: sequencer for the picture quantizer controller
// Accepts one word at a time, steps the datapath through the divisions,
// multiply and rounding, and owns the output valid flag.
// ----------------------------------------------------------------------------
module frq_ctrl
  import frq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       in_mode,
  input  logic       cfg_wr,
  output logic       cfg_ready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output ctl_cmd_t   cmd,
  input  dp_status_t status
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       go_div;

  // Take register writes only between items; a write wins over an input word
  assign cfg_ready = (state_r == ST_IDLE) || (state_r == ST_RELOAD);
  assign in_tready = (state_r == ST_IDLE) && !cfg_wr;

  assign accept = in_tvalid && in_tready;
  assign go_div = (in_mode == MODE_BEGIN) && status.rate_mode && !status.actual_zero;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RELOAD: begin
        state_nxt = cfg_wr ? ST_RELOAD : ST_IDLE;
      end
      ST_IDLE: begin
        priority if (cfg_wr) begin
          state_nxt = ST_RELOAD;
        end else if (accept) begin
          priority if (in_mode == MODE_END) begin
            state_nxt = status.rate_mode ? ST_ACC_MUL : ST_IDLE;
          end else if (go_div) begin
            state_nxt = ST_DIV_MEAN;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_DIV_MEAN: begin
        if (status.div_done) begin
          state_nxt = ST_DIV_ADJ;
        end
      end
      ST_DIV_ADJ: begin
        if (status.div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:     state_nxt = ST_ROUND;
      ST_ROUND:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ACC_MUL: state_nxt = ST_ACC_ADD;
      ST_ACC_ADD: state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_RELOAD: cmd.reload = 1'b1;
      ST_IDLE: begin
        cmd.take_in = accept;
        if (accept && go_div) begin
          cmd.div_start = 1'b1;
          cmd.div_frac  = 1'b1;
        end
      end
      ST_DIV_MEAN: begin
        if (status.div_done) begin
          cmd.cap_mean  = 1'b1;
          cmd.div_start = 1'b1;
        end
      end
      ST_DIV_ADJ: cmd.cap_adj  = status.div_done;
      ST_MUL:     cmd.mul      = 1'b1;
      ST_ROUND:   cmd.round_q  = 1'b1;
      ST_EMIT:    cmd.out_load = !out_valid_r || out_tready;
      ST_ACC_MUL: cmd.acc_mul  = 1'b1;
      ST_ACC_ADD: cmd.acc_add  = 1'b1;
      default:    cmd          = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RELOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while full");

  // A blocked result keeps the sequencer waiting
  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && !out_tready) |=> (state_r == ST_EMIT))
    else $error("result dropped while output stalled");

  // Divider completions only land while a division is expected
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> (state_r == ST_DIV_MEAN || state_r == ST_DIV_ADJ))
    else $error("divider finished outside a division state");

  // A fixed-mode begin picture goes straight to the output
  a_fixed_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg_wr && in_mode == MODE_BEGIN && !status.rate_mode)
      |=> (state_r == ST_EMIT))
    else $error("fixed-mode request did not emit");

endmodule

// ===== sv/frame_quantizer_rate_control.sv =====
// ----------------------------------------------------------------------------
// frame_quantizer_rate_control: picture-level quantizer controller
// Frame-level variable bitrate control. Tracks produced, wanted and
// bits-times-quantizer totals and hands out the quantizer for each picture.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                          | Word contents (low bit first)
//  --------+--------------------------------+---------------------------------
//  input   | in_tvalid/in_tready/in_tdata/  | tdata: picture_bytes[17:0], pad
//          | in_tuser                       | tuser: mode (0 begin, 1 end)
//  result  | out_tvalid/out_tready/out_tdata| tdata: quantizer[4:0], pad
//  config  | cfg_valid/cfg_ready/cfg_index/ | index 0 control_mode, 1
//          | cfg_data                       | initial_quant, 2 target_bitrate,
//          |                                | 3 frame_budget
//
// Steps: a begin-picture word in rate mode runs two divisions on the
//   shared one-bit-per-cycle divider, the mean quantizer and then the rate
//   error division, then a multiply and a rounding step before the output.
//   Fixed mode, or zero produced bits: straight to the output register.
//   An end-picture word in rate mode runs a multiply, then a saturating
//   add; in fixed mode it updates no accumulator.
// Reset: one reload cycle follows reset and each register write, during
//   which in_tready is low; the accumulators are rebuilt from the registers.
//   cfg_ready is high only between items; a write beats an input word.
// Stalls: a finished quantizer waits in the output register; the next word
//   is taken meanwhile, and its own result waits until that one is drained.
//
module frame_quantizer_rate_control
  import frq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [17:0] picture_bytes, [23:18] zero
  input  logic [MODE_W-1:0]     in_tuser,   // [0] mode
  // result words
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [4:0] quantizer, [7:5] zero
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t           cmd;
  dp_status_t         status;
  logic               cfg_wr;
  logic [QUANT_W-1:0] out_quant;

  // Registers are writable between items; the sequencer reloads after each write
  assign cfg_wr = cfg_valid && cfg_ready;

  frq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser[0]),
    .cfg_wr     (cfg_wr),
    .cfg_ready  (cfg_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  frq_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_bytes  (in_tdata[BYTES_W-1:0]),
    .out_quant (out_quant)
  );

  // Pad the quantizer out to a whole byte
  assign out_tdata = {{(OUT_DATA_W-QUANT_W){1'b0}}, out_quant};

endmodule
